/* rtl/stb_pkg.sv */
`default_nettype none

package stb_pkg;

   // bank size and derived widths
   localparam int TIMER_COUNT  = 8;
   localparam int TMR_IDX_W    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int TMR_CNT_W    = $clog2(TIMER_COUNT + 1);
   localparam int RESULT_LIMIT = 8;
   localparam int EV_W         = $clog2(RESULT_LIMIT + 1);

   localparam logic [15:0] PRESCALE_RESET = 16'd100;

   // command codes
   typedef enum logic [3:0] {
      OP_TICK       = 4'd0,
      OP_ARM        = 4'd1,
      OP_STOP       = 4'd2,
      OP_CONTINUE   = 4'd3,
      OP_RESTART    = 4'd4,
      OP_WRITE_CNT  = 4'd5,
      OP_READ_CNT   = 4'd6,
      OP_POLL       = 4'd7,
      OP_READ_SLOW  = 4'd8,
      OP_READ_FINE  = 4'd9
   } op_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD,
      ST_FINE,
      ST_PRESCALE,
      ST_SLOWCHK,
      ST_SLOW,
      ST_WALK,
      ST_REPLY,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // write request into the timer register file
   typedef struct packed {
      logic        en_we;
      logic        en_val;
      logic        per_we;
      logic        per_val;
      logic        tmo_we;
      logic [31:0] tmo_val;
      logic        cnt_we;
      logic [31:0] cnt_val;
   } tmr_wr_type;

   // read data of the addressed timer
   typedef struct packed {
      logic        enabled;
      logic        periodic;
      logic [31:0] timeout;
      logic [31:0] count;
   } tmr_rd_type;

endpackage

`default_nettype wire

/* rtl/stb_channels.sv */
`default_nettype none

// command word channel
interface stb_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [3:0]  timer_index;
   logic [31:0] value;
   logic        periodic;

   modport source (output valid, operation, timer_index, value, periodic, input ready);
   modport sink   (input valid, operation, timer_index, value, periodic, output ready);
endinterface

// result word channel
interface stb_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] read_value;
   logic        expired;
   logic [3:0]  expired_index;
   logic        last;

   modport source (output valid, status, read_value, expired, expired_index, last,
                   input ready);
   modport sink   (input valid, status, read_value, expired, expired_index, last,
                   output ready);
endinterface

// prescale register write channel
interface stb_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] prescale_ratio;

   modport source (output valid, prescale_ratio, input ready);
   modport sink   (input valid, prescale_ratio, output ready);
endinterface

`default_nettype wire

/* rtl/stb_alu.sv */
`default_nettype none

module stb_alu import stb_pkg::*; (
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] inc,
   output logic        ge
);

   // shared incrementer and magnitude compare
   assign inc = op_a + 32'd1;
   assign ge  = (op_a >= op_b);

endmodule

`default_nettype wire

/* rtl/stb_timer_regs.sv */
`default_nettype none

module stb_timer_regs import stb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [TMR_IDX_W-1:0] addr,
   input  tmr_wr_type           wr,
   output tmr_rd_type           rd
);

   logic        enabled_ff  [TIMER_COUNT];
   logic        periodic_ff [TIMER_COUNT];
   logic [31:0] timeout_ff  [TIMER_COUNT];
   logic [31:0] count_ff    [TIMER_COUNT];

   // single read port at the sequencer address
   always_comb begin
      rd.enabled  = enabled_ff[addr];
      rd.periodic = periodic_ff[addr];
      rd.timeout  = timeout_ff[addr];
      rd.count    = count_ff[addr];
   end

   // single write port at the same address
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            enabled_ff[i]  <= 1'b0;
            periodic_ff[i] <= 1'b0;
            timeout_ff[i]  <= '0;
            count_ff[i]    <= '0;
         end
      end else begin
         if (wr.en_we)  enabled_ff[addr]  <= wr.en_val;
         if (wr.per_we) periodic_ff[addr] <= wr.per_val;
         if (wr.tmo_we) timeout_ff[addr]  <= wr.tmo_val;
         if (wr.cnt_we) count_ff[addr]    <= wr.cnt_val;
      end
   end

endmodule

`default_nettype wire

/* rtl/stb_ctrl.sv */
`default_nettype none

module stb_ctrl import stb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   stb_req_if.sink              req_port,
   stb_rsp_if.source            rsp_port,
   stb_csr_if.sink              csr_port,
   output logic [31:0]          alu_a,
   output logic [31:0]          alu_b,
   input  logic [31:0]          alu_inc,
   input  logic                 alu_ge,
   output logic [TMR_IDX_W-1:0] tmr_addr,
   output tmr_wr_type           tmr_wr,
   input  tmr_rd_type           tmr_rd
);

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [3:0]            idx_ff, idx_in;
   logic [31:0]           val_ff, val_in;
   logic                  per_ff, per_in;
   logic [31:0]           fine_ff, fine_in;
   logic [31:0]           slow_ff, slow_in;
   logic [15:0]           pc_ff, pc_in;
   logic [15:0]           ratio_ff, ratio_in;
   logic [TMR_CNT_W-1:0]  walk_ff, walk_in;
   logic [EV_W-1:0]       ev_ff, ev_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [TMR_IDX_W-1:0]  pend_idx_ff, pend_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_read_ff, rsp_read_in;
   logic                  rsp_expired_ff, rsp_expired_in;
   logic [3:0]            rsp_exp_idx_ff, rsp_exp_idx_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  idx_ok;
   logic                  walk_done;
   logic [TMR_IDX_W-1:0]  walk_idx;
   logic [15:0]           ratio_eff;
   logic                  push;
   logic                  push_status;
   logic [31:0]           push_read;
   logic                  push_expired;
   logic [3:0]            push_idx;
   logic                  push_last;

   // handshakes
   assign req_port.ready = (state_ff == ST_IDLE);
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_status_ff;
   assign rsp_port.read_value    = rsp_read_ff;
   assign rsp_port.expired       = rsp_expired_ff;
   assign rsp_port.expired_index = rsp_exp_idx_ff;
   assign rsp_port.last          = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign idx_ok    = ({1'b0, idx_ff} < 5'(TIMER_COUNT));
   assign walk_done = (walk_ff == TMR_CNT_W'(TIMER_COUNT));
   assign walk_idx  = walk_ff[TMR_IDX_W-1:0];
   assign ratio_eff = (ratio_ff == 16'd0) ? 16'd1 : ratio_ff;

   // sequencer next state and datapath control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      per_in        = per_ff;
      fine_in       = fine_ff;
      slow_in       = slow_ff;
      pc_in         = pc_ff;
      ratio_in      = ratio_ff;
      walk_in       = walk_ff;
      ev_in         = ev_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      alu_a         = '0;
      alu_b         = '0;
      tmr_addr      = walk_idx;
      tmr_wr        = '0;
      push          = 1'b0;
      push_status   = 1'b0;
      push_read     = '0;
      push_expired  = 1'b0;
      push_idx      = '0;
      push_last     = 1'b0;

      if (csr_port.valid) begin
         ratio_in = csr_port.prescale_ratio;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               op_in         = op_type'(req_port.operation);
               idx_in        = req_port.timer_index;
               val_in        = req_port.value;
               per_in        = req_port.periodic;
               walk_in       = '0;
               ev_in         = '0;
               pend_valid_in = 1'b0;
               if (req_port.operation == OP_TICK) begin
                  state_in = ST_FINE;
               end else if (req_port.operation == OP_POLL) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end

         // single-word commands
         ST_CMD: begin
            tmr_addr = idx_ff[TMR_IDX_W-1:0];
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = ST_IDLE;
               unique case (op_ff)
                  OP_ARM: begin
                     push_status = !idx_ok;
                     if (idx_ok) begin
                        tmr_wr.en_we   = 1'b1;
                        tmr_wr.en_val  = 1'b1;
                        tmr_wr.per_we  = 1'b1;
                        tmr_wr.per_val = per_ff;
                        tmr_wr.tmo_we  = 1'b1;
                        tmr_wr.tmo_val = val_ff;
                        tmr_wr.cnt_we  = 1'b1;
                        tmr_wr.cnt_val = '0;
                     end
                  end
                  OP_STOP: begin
                     push_status = !idx_ok;
                     if (idx_ok) begin
                        tmr_wr.en_we  = 1'b1;
                        tmr_wr.en_val = 1'b0;
                     end
                  end
                  OP_CONTINUE: begin
                     push_status = !idx_ok;
                     if (idx_ok) begin
                        tmr_wr.en_we  = 1'b1;
                        tmr_wr.en_val = 1'b1;
                     end
                  end
                  OP_RESTART: begin
                     push_status = !idx_ok;
                     if (idx_ok) begin
                        tmr_wr.en_we   = 1'b1;
                        tmr_wr.en_val  = 1'b1;
                        tmr_wr.cnt_we  = 1'b1;
                        tmr_wr.cnt_val = '0;
                     end
                  end
                  OP_WRITE_CNT: begin
                     push_status = !idx_ok;
                     if (idx_ok) begin
                        tmr_wr.cnt_we  = 1'b1;
                        tmr_wr.cnt_val = val_ff;
                     end
                  end
                  OP_READ_CNT: begin
                     push_status = !idx_ok;
                     push_read   = idx_ok ? tmr_rd.count : 32'd0;
                  end
                  OP_READ_SLOW: push_read = slow_ff;
                  OP_READ_FINE: push_read = fine_ff;
                  default: ;
               endcase
            end
         end

         // tick: fine count, prescaler, slow tick check
         ST_FINE: begin
            alu_a    = fine_ff;
            fine_in  = alu_inc;
            state_in = ST_PRESCALE;
         end
         ST_PRESCALE: begin
            alu_a    = {16'd0, pc_ff};
            pc_in    = alu_inc[15:0];
            state_in = ST_SLOWCHK;
         end
         ST_SLOWCHK: begin
            alu_a = {16'd0, pc_ff};
            alu_b = {16'd0, ratio_eff};
            if (alu_ge || (pc_ff == 16'd0)) begin
               pc_in    = '0;
               state_in = ST_SLOW;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_SLOW: begin
            alu_a    = slow_ff;
            slow_in  = alu_inc;
            walk_in  = '0;
            state_in = ST_WALK;
         end

         // slow tick: bump every enabled timer, one per cycle
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_REPLY;
            end else begin
               alu_a = tmr_rd.count;
               if (tmr_rd.enabled) begin
                  tmr_wr.cnt_we  = 1'b1;
                  tmr_wr.cnt_val = alu_inc;
               end
               walk_in = walk_ff + TMR_CNT_W'(1);
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         // poll: scan timers, hold the newest event until its successor is known
         ST_SCAN: begin
            if (walk_done || (ev_ff == EV_W'(RESULT_LIMIT))) begin
               state_in = ST_FLUSH;
            end else begin
               alu_a = tmr_rd.count;
               alu_b = tmr_rd.timeout;
               if (tmr_rd.enabled && alu_ge) begin
                  if (!pend_valid_ff || out_free) begin
                     if (pend_valid_ff) begin
                        push         = 1'b1;
                        push_expired = 1'b1;
                        push_idx     = 4'(pend_idx_ff);
                     end
                     if (tmr_rd.periodic) begin
                        tmr_wr.cnt_we  = 1'b1;
                        tmr_wr.cnt_val = '0;
                     end else begin
                        tmr_wr.en_we  = 1'b1;
                        tmr_wr.en_val = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_idx_in   = walk_idx;
                     ev_in         = ev_ff + EV_W'(1);
                     walk_in       = walk_ff + TMR_CNT_W'(1);
                  end
               end else begin
                  walk_in = walk_ff + TMR_CNT_W'(1);
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               push_expired  = pend_valid_ff;
               push_idx      = pend_valid_ff ? 4'(pend_idx_ff) : 4'd0;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_exp_idx_in = rsp_exp_idx_ff;
      rsp_last_in    = rsp_last_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = push_status;
         rsp_read_in    = push_read;
         rsp_expired_in = push_expired;
         rsp_exp_idx_in = push_idx;
         rsp_last_in    = push_last;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fine_ff       <= '0;
         slow_ff       <= '0;
         pc_ff         <= '0;
         ratio_ff      <= PRESCALE_RESET;
         walk_ff       <= '0;
         ev_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fine_ff       <= fine_in;
         slow_ff       <= slow_in;
         pc_ff         <= pc_in;
         ratio_ff      <= ratio_in;
         walk_ff       <= walk_in;
         ev_ff         <= ev_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      val_ff         <= val_in;
      per_ff         <= per_in;
      pend_idx_ff    <= pend_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_exp_idx_ff <= rsp_exp_idx_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // no pending event survives the end of a poll
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending event left after poll");

   // event count never passes the per-poll limit
   a_ev_limit: assert property (@(posedge clock) disable iff (reset)
      ev_ff <= EV_W'(RESULT_LIMIT))
      else $error("poll event count overflow");

   // walk pointer never runs past the bank
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= TMR_CNT_W'(TIMER_COUNT))
      else $error("timer walk out of range");

   // an idle sequencer never produces a word
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result word produced while idle");

endmodule

`default_nettype wire

/* rtl/software_timer_bank_core.sv */
`default_nettype none

// Bank of TIMER_COUNT millisecond timers run by one sequencer over a shared
// incrementer/comparator and a single-port timer register file. A command word
// is taken when the block is idle; arm, stop, continue, restart, counter
// write/read and tick-count reads pass through ST_CMD, which loads the result
// register once the result channel is free. A tick steps the fine count, the
// prescaler and the slow tick check; when it fires the slow tick, every timer
// is visited once through the shared unit.
// A poll scans the timers and waits whenever the result channel stalls; it
// gives one word per expired timer (at most 8, last flagged) or one empty
// word. The next command is taken as soon as the block is back in idle, even
// while the final result word still waits to be taken. The prescale register
// (reset 100, 0 acts as 1) is always ready and is meant to be written between
// commands.
module software_timer_bank_core import stb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   stb_req_if.sink   req_port,
   stb_rsp_if.source rsp_port,
   stb_csr_if.sink   csr_port
);

   logic [31:0]          alu_a;
   logic [31:0]          alu_b;
   logic [31:0]          alu_inc;
   logic                 alu_ge;
   logic [TMR_IDX_W-1:0] tmr_addr;
   tmr_wr_type           tmr_wr;
   tmr_rd_type           tmr_rd;

   // sequencer, tick counters and result register
   stb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .csr_port (csr_port),
      .alu_a    (alu_a),
      .alu_b    (alu_b),
      .alu_inc  (alu_inc),
      .alu_ge   (alu_ge),
      .tmr_addr (tmr_addr),
      .tmr_wr   (tmr_wr),
      .tmr_rd   (tmr_rd)
   );

   // shared arithmetic unit
   stb_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .inc  (alu_inc),
      .ge   (alu_ge)
   );

   // per-timer state
   stb_timer_regs u_regs (
      .clock (clock),
      .reset (reset),
      .addr  (tmr_addr),
      .wr    (tmr_wr),
      .rd    (tmr_rd)
   );

endmodule

`default_nettype wire
